>>> sv/qyt_pkg.sv
`timescale 1ns / 1ps

package qyt_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int ATAN_N           = 24;
  localparam int ATAN_IW          = 5;
  localparam int ACC_W            = 33;
  localparam int QD_W             = 34;
  localparam int XW               = 36;
  localparam int SUM_W            = 24;
  localparam int DIV_BITS         = 24;
  localparam int DIV_CW           = $clog2(DIV_BITS);
  localparam int CNT_W            = 8;
  localparam int REM_W            = 9;

  localparam logic [CNT_W-1:0] CALIB_RESET = 8'd100;
  localparam logic [15:0]      CENTI_SCALE = 16'd36000;
  localparam logic [31:0]      CENTI_ROUND = 32'd32768;
  localparam logic [QD_W-1:0]  DEN_ONE     = 34'd268435456;

  localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {
    MUL_WZ = 2'd0,
    MUL_XY = 2'd1,
    MUL_YY = 2'd2,
    MUL_ZZ = 2'd3
  } qyt_mul_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic prep;
    logic cord;
    logic angle;
    logic out_load;
    logic div_init;
    logic div_step;
  } qyt_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic cord_last;
    logic div_req;
    logic div_last;
    logic out_free;
  } qyt_sts_t;

  function automatic logic [31:0] atan_turn(input logic [ATAN_IW-1:0] idx);
    logic [31:0] v;
    v = '0;
    if (32'(idx) < ATAN_N) begin
      v = ATAN_TURN32[idx];
    end
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    return (v == '0) ? CNT_W'(1) : v;
  endfunction

endpackage

>>> sv/qyt_channels.sv
`timescale 1ns / 1ps

interface qyt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               restart_calibration;

  modport source(output valid, quat_w, quat_x, quat_y, quat_z, restart_calibration,
                 input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, restart_calibration,
               output ready);
endinterface

interface qyt_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] yaw_angle;
  logic        [15:0] yaw_centideg;
  logic signed [15:0] raw_yaw;
  logic               calibrated;

  modport source(output valid, yaw_angle, yaw_centideg, raw_yaw, calibrated, input ready);
  modport sink(input valid, yaw_angle, yaw_centideg, raw_yaw, calibrated, output ready);
endinterface

>>> sv/qyt_ctrl.sv
`timescale 1ns / 1ps

module qyt_ctrl
  import qyt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  qyt_sts_t sts,
  output qyt_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_PREP  = 7'b0000100,
    ST_CORD  = 7'b0001000,
    ST_ANGLE = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_DIV   = 7'b1000000
  } qyt_state_t;

  qyt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (sts.mul_last) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        cmd.cord = 1'b1;
        if (sts.cord_last) begin
          state_nxt = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd.angle = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.div_req) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/qyt_datapath.sv
`timescale 1ns / 1ps

module qyt_datapath
  import qyt_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF,
  parameter int AB    = ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qyt_cmd_t           cmd,
  output qyt_sts_t           sts,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic               in_restart,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_yaw_angle,
  output logic [15:0]        out_yaw_centideg,
  output logic signed [15:0] out_raw_yaw,
  output logic               out_calibrated
);

  localparam int SW = $clog2(STEPS);

  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic               restart_r;
  qyt_mul_t           mul_sel_r;
  logic signed [ACC_W-1:0] acc_a_r, acc_b_r;
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod;

  logic signed [XW-1:0] x_r, y_r;
  logic [AB-1:0]        z_r;
  logic                 zero_r;
  logic [SW-1:0]        step_r;

  logic signed [QD_W-1:0] num_q, den_q;
  logic signed [XW-1:0]   num_x, den_x, dx, dy;
  logic [32:0]            t_full;
  logic [AB-1:0]          t_step;

  logic [15:0] raw16, raw_fin, rel, eff_off;
  logic        eff_valid;
  logic signed [SUM_W-1:0] base_sum;
  logic [CNT_W-1:0]        base_taken, base_left, taken_nxt, left_nxt;

  logic [CNT_W-1:0]        calib_r, taken_r, left_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [15:0]             offset_r;
  logic                    offset_valid_r;
  logic                    div_req_r;

  logic [15:0] rel_r, raw_r;
  logic        cal_r;

  logic [REM_W-1:0]  n_val, n_r, rem_r, rem_nxt;
  logic [SUM_W-1:0]  mag, dvd_r, quo;
  logic [REM_W:0]    trial;
  logic              ge, neg_r;
  logic [DIV_CW-1:0] div_cnt_r;

  logic [31:0] centi_prod;
  logic        out_valid_r;

  always_comb begin
    mul_a = qw_r;
    mul_b = qz_r;
    case (mul_sel_r)
      MUL_WZ: begin mul_a = qw_r; mul_b = qz_r; end
      MUL_XY: begin mul_a = qx_r; mul_b = qy_r; end
      MUL_YY: begin mul_a = qy_r; mul_b = qy_r; end
      MUL_ZZ: begin mul_a = qz_r; mul_b = qz_r; end
      default: begin mul_a = qw_r; mul_b = qz_r; end
    endcase
    prod = mul_a * mul_b;
  end

  assign num_q = {acc_a_r, 1'b0};
  assign den_q = $signed(DEN_ONE) - $signed({acc_b_r, 1'b0});
  assign num_x = {{(XW-QD_W){num_q[QD_W-1]}}, num_q};
  assign den_x = {{(XW-QD_W){den_q[QD_W-1]}}, den_q};

  assign dx     = y_r >>> step_r;
  assign dy     = x_r >>> step_r;
  assign t_full = {1'b0, atan_turn(ATAN_IW'(step_r))} + (33'd1 << (31 - AB));
  assign t_step = t_full[32-AB +: AB];

  generate
    if (AB > 16) begin : g_round
      logic [AB:0] z_rnd;
      assign z_rnd = {1'b0, z_r} + ((AB + 1)'(1) << (AB - 17));
      assign raw16 = z_rnd[AB-16 +: 16];
    end else begin : g_widen
      assign raw16 = 16'(z_r) << (16 - AB);
    end
  endgenerate

  assign raw_fin    = zero_r ? 16'd0 : raw16;
  assign eff_valid  = restart_r ? 1'b0 : offset_valid_r;
  assign eff_off    = eff_valid ? offset_r : 16'd0;
  assign rel        = raw_fin - eff_off;
  assign base_sum   = restart_r ? '0 : sum_r;
  assign base_taken = restart_r ? '0 : taken_r;
  assign base_left  = restart_r ? eff_count(calib_r) : left_r;
  assign taken_nxt  = base_taken + CNT_W'(1);
  assign left_nxt   = (base_left == '0) ? '0 : base_left - CNT_W'(1);

  assign n_val   = (taken_r == '0) ? REM_W'(256) : {1'b0, taken_r};
  assign mag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign trial   = {rem_r, dvd_r[SUM_W-1]};
  assign ge      = trial >= {1'b0, n_r};
  assign rem_nxt = ge ? REM_W'(trial - {1'b0, n_r}) : trial[REM_W-1:0];
  assign quo     = {dvd_r[SUM_W-2:0], ge};

  assign centi_prod = rel_r * CENTI_SCALE + CENTI_ROUND;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qw_r      <= in_quat_w;
      qx_r      <= in_quat_x;
      qy_r      <= in_quat_y;
      qz_r      <= in_quat_z;
      restart_r <= in_restart;
      mul_sel_r <= MUL_WZ;
      acc_a_r   <= '0;
      acc_b_r   <= '0;
    end
    if (cmd.mul) begin
      mul_sel_r <= qyt_mul_t'(mul_sel_r + 2'd1);
      case (mul_sel_r) inside
        MUL_WZ, MUL_XY: acc_a_r <= acc_a_r + ACC_W'(prod);
        default:        acc_b_r <= acc_b_r + ACC_W'(prod);
      endcase
    end
    if (cmd.prep) begin
      step_r <= '0;
      zero_r <= (num_q == '0) && (den_q == '0);
      if (den_q < 0) begin
        x_r <= -den_x;
        y_r <= -num_x;
        z_r <= {1'b1, {(AB-1){1'b0}}};
      end else begin
        x_r <= den_x;
        y_r <= num_x;
        z_r <= '0;
      end
    end
    if (cmd.cord) begin
      step_r <= step_r + SW'(1);
      if (!y_r[XW-1]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + t_step;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - t_step;
      end
    end
    if (cmd.angle) begin
      rel_r <= rel;
      raw_r <= raw_fin;
      cal_r <= eff_valid;
    end
    if (cmd.out_load) begin
      out_yaw_angle    <= rel_r;
      out_yaw_centideg <= centi_prod[31:16];
      out_raw_yaw      <= raw_r;
      out_calibrated   <= cal_r;
    end
    if (cmd.div_init) begin
      n_r       <= n_val;
      neg_r     <= sum_r[SUM_W-1];
      dvd_r     <= mag + SUM_W'(n_val >> 1);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      dvd_r     <= quo;
      div_cnt_r <= div_cnt_r + DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r        <= CALIB_RESET;
      left_r         <= CALIB_RESET;
      taken_r        <= '0;
      sum_r          <= '0;
      offset_r       <= '0;
      offset_valid_r <= 1'b0;
      div_req_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      calib_r <= cfg_wr_data;
      if (!offset_valid_r && taken_r == '0) begin
        left_r <= eff_count(cfg_wr_data);
      end
    end else if (cmd.angle) begin
      div_req_r <= 1'b0;
      if (restart_r) begin
        offset_r       <= '0;
        offset_valid_r <= 1'b0;
      end
      if (!eff_valid) begin
        sum_r     <= base_sum + SUM_W'(signed'(raw_fin));
        taken_r   <= taken_nxt;
        left_r    <= left_nxt;
        div_req_r <= (left_nxt == '0) || (taken_nxt == '0);
      end
    end else if (cmd.div_step && sts.div_last) begin
      offset_r       <= neg_r ? 16'(-quo) : quo[15:0];
      offset_valid_r <= 1'b1;
      div_req_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.mul_last  = (mul_sel_r == MUL_ZZ);
  assign sts.cord_last = (step_r == SW'(STEPS - 1));
  assign sts.div_req   = div_req_r;
  assign sts.div_last  = (div_cnt_r == DIV_CW'(DIV_BITS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

>>> sv/quaternion_yaw_tracker_unit.sv
// Yaw tracker: takes one orientation quaternion (Q1.14) per transaction and returns one
// result with the absolute yaw, the yaw relative to a calibrated zero as a binary angle
// and in centidegrees, and a calibrated flag. The block works on one sample at a time:
// the next input transaction is taken only after four passes through one shared
// 16x16 multiplier and CORDIC_STEPS passes through one iterative vectoring CORDIC
// stage. The sample that completes calibration also runs the bit-serial divider that
// forms the mean offset. The result sits in an output register, so a stalled output
// only holds the block once the next result is ready. Write calib_samples only while
// no transaction is in flight; a write before the first calibration sample reloads
// the sample count at once.
`timescale 1ns / 1ps

module quaternion_yaw_tracker_unit
  import qyt_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  qyt_in_if.sink           in_ch,
  qyt_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  localparam int STEPS = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;

  qyt_cmd_t cmd;
  qyt_sts_t sts;
  logic     ready;

  qyt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qyt_datapath #(
    .STEPS (STEPS),
    .AB    (ANGLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_quat_w        (in_ch.quat_w),
    .in_quat_x        (in_ch.quat_x),
    .in_quat_y        (in_ch.quat_y),
    .in_quat_z        (in_ch.quat_z),
    .in_restart       (in_ch.restart_calibration),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_yaw_angle    (out_ch.yaw_angle),
    .out_yaw_centideg (out_ch.yaw_centideg),
    .out_raw_yaw      (out_ch.raw_yaw),
    .out_calibrated   (out_ch.calibrated)
  );

  assign in_ch.ready = ready;

endmodule

>>> sv/qyt_checker.sv
`timescale 1ns / 1ps

module qyt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] yaw_angle,
  input logic [15:0] yaw_centideg,
  input logic [15:0] raw_yaw,
  input logic        calibrated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(yaw_angle) && $stable(raw_yaw))
    else $error("result changed while stalled");

  a_centi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> yaw_centideg <= 16'd35999)
    else $error("centidegree value out of range");

  a_uncal_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !calibrated |-> yaw_angle == raw_yaw)
    else $error("relative yaw differs from raw yaw during calibration");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind quaternion_yaw_tracker_unit qyt_checker u_qyt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .yaw_angle    (out_ch.yaw_angle),
  .yaw_centideg (out_ch.yaw_centideg),
  .raw_yaw      (out_ch.raw_yaw),
  .calibrated   (out_ch.calibrated)
);

>>> tb/sv/quaternion_yaw_tracker_unit_test.sv
`timescale 1ns / 1ps

module quaternion_yaw_tracker_unit_test;
  import qyt_pkg::*;

  localparam int YAW_ACC_BITS  = ANGLE_BITS_DEF;
  localparam int YAW_STEPS     = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
  localparam int ANG_DOWN      = (YAW_ACC_BITS > 16) ? YAW_ACC_BITS - 16 : 0;
  localparam int ANG_UP        = (YAW_ACC_BITS < 16) ? 16 - YAW_ACC_BITS : 0;
  localparam longint unsigned ANG_HALF = (ANG_DOWN > 0) ? (64'd1 << (ANG_DOWN - 1)) : 64'd0;
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEM_TARGET   = 1200;

  localparam logic [31:0] ROT_ANGLE_TURN32 [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               restart;
  } quat_sample_t;

  typedef struct packed {
    logic        [15:0] yaw_angle;
    logic        [15:0] yaw_centideg;
    logic signed [15:0] raw_yaw;
    logic               calibrated;
  } yaw_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  qyt_in_if  in_ch();
  qyt_out_if out_ch();

  quaternion_yaw_tracker_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  yaw_result_t yaw_expected[$];
  int          error_count = 0;
  int          samples_sent = 0;
  bit          idle_on = 1'b1;
  int          out_hold_cycles = 0;

  logic [7:0]  calib_cfg = 8'd100;
  int          yaw_total = 0;
  int unsigned calib_left = 100;
  logic [7:0]  calib_taken = 8'd0;
  logic [15:0] zero_offset = 16'd0;
  bit          offset_ready = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** quaternion_yaw_tracker_unit: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 30);
    return $urandom_range(40, 120);
  endfunction

  function automatic logic [15:0] cordic_yaw(input longint num_in, input longint den_in);
    longint            yv;
    longint            xv;
    longint            dx;
    longint            dy;
    longint unsigned   acc;
    longint unsigned   t;
    longint unsigned   amask;
    yv = num_in;
    xv = den_in;
    acc = 0;
    amask = (64'd1 << YAW_ACC_BITS) - 1;
    if (xv == 0 && yv == 0) return 16'd0;
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      acc = 64'd1 << (YAW_ACC_BITS - 1);
    end
    for (int i = 0; i < YAW_STEPS; i++) begin
      t = (64'(ROT_ANGLE_TURN32[i]) + (64'd1 << (31 - YAW_ACC_BITS))) >> (32 - YAW_ACC_BITS);
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv = xv + dx;
        yv = yv - dy;
        acc = (acc + t) & amask;
      end else begin
        xv = xv - dx;
        yv = yv + dy;
        acc = (acc - t) & amask;
      end
    end
    return 16'(((acc + ANG_HALF) >> ANG_DOWN) << ANG_UP);
  endfunction

  function automatic int unsigned calib_target(input logic [7:0] v);
    return (v == 8'd0) ? 1 : int'(v);
  endfunction

  task automatic track_yaw(input quat_sample_t s, output yaw_result_t r);
    longint      w;
    longint      x;
    longint      y;
    longint      z;
    logic [15:0] raw;
    logic [15:0] rel;
    int unsigned n;
    int unsigned mag;
    int unsigned q;
    bit          was_ready;
    w = s.w;
    x = s.x;
    y = s.y;
    z = s.z;
    raw = cordic_yaw(2 * (w * z + x * y), (longint'(1) << 28) - 2 * (y * y + z * z));
    if (s.restart) begin
      yaw_total = 0;
      calib_taken = 8'd0;
      calib_left = calib_target(calib_cfg);
      zero_offset = 16'd0;
      offset_ready = 1'b0;
    end
    was_ready = offset_ready;
    rel = raw - (was_ready ? zero_offset : 16'd0);
    if (!offset_ready) begin
      yaw_total = yaw_total + int'($signed(raw));
      calib_taken = calib_taken + 8'd1;
      calib_left = (calib_left == 0) ? 0 : calib_left - 1;
      if (calib_left == 0 || calib_taken == 8'd0) begin
        n = (calib_taken == 8'd0) ? 256 : int'(calib_taken);
        mag = (yaw_total < 0) ? -yaw_total : yaw_total;
        q = (mag + n / 2) / n;
        zero_offset = 16'((yaw_total < 0) ? -q : q);
        offset_ready = 1'b1;
      end
    end
    r.yaw_angle = rel;
    r.yaw_centideg = 16'((32'(rel) * 32'd36000 + 32'd32768) >> 16);
    r.raw_yaw = raw;
    r.calibrated = was_ready;
  endtask

  function automatic quat_sample_t quat(input int w, input int x, input int y, input int z,
                                        input bit restart);
    quat_sample_t s;
    s.w = 16'(w);
    s.x = 16'(x);
    s.y = 16'(y);
    s.z = 16'(z);
    s.restart = restart;
    return s;
  endfunction

  function automatic quat_sample_t random_sample(input bit restart);
    real          a[4];
    real          len;
    quat_sample_t s;
    len = 0.0;
    if ($urandom_range(0, 6) == 0) begin
      s = quat($urandom, $urandom, $urandom, $urandom, restart);
    end else begin
      for (int k = 0; k < 4; k++) begin
        a[k] = real'(int'($urandom_range(0, 2000)) - 1000);
        len = len + a[k] * a[k];
      end
      if (len == 0.0) begin
        a[0] = 1.0;
        len = 1.0;
      end
      len = $sqrt(len);
      s = quat($rtoi(a[0] / len * 16384.0), $rtoi(a[1] / len * 16384.0),
               $rtoi(a[2] / len * 16384.0), $rtoi(a[3] / len * 16384.0), restart);
    end
    return s;
  endfunction

  task automatic send_sample(input quat_sample_t s);
    yaw_result_t r;
    int          gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.quat_w <= s.w;
    in_ch.quat_x <= s.x;
    in_ch.quat_y <= s.y;
    in_ch.quat_z <= s.z;
    in_ch.restart_calibration <= s.restart;
    do @(posedge clk); while (!in_ch.ready);
    track_yaw(s, r);
    yaw_expected.push_back(r);
    samples_sent++;
  endtask

  task automatic send_random_run(input int count);
    for (int k = 0; k < count; k++) begin
      send_sample(random_sample(k == 0 || $urandom_range(0, 59) == 0));
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (yaw_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_calib_samples(input logic [7:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    calib_cfg = v;
    if (!offset_ready && calib_taken == 8'd0) calib_left = calib_target(v);
  endtask

  // count of zero acts as one; written before any sample so the count reloads
  task automatic test_zero_count_and_special_angles();
    write_calib_samples(8'd0);
    send_sample(quat(16384, 0, 0, 0, 1'b0));
    send_sample(quat(100, -100, 8192, 8192, 1'b0));
    send_sample(quat(0, 0, 0, 16384, 1'b0));
    send_sample(quat(0, 0, 16384, 0, 1'b0));
    send_sample(quat(-1, 0, 0, 16384, 1'b0));
    send_sample(quat(1, 0, 0, 16384, 1'b0));
    send_sample(quat(11585, 0, 0, 11585, 1'b0));
    send_sample(quat(16384, 0, 0, -11585, 1'b0));
    send_sample(quat(32767, 32767, 32767, 32767, 1'b0));
    send_sample(quat(-32768, -32768, -32768, -32768, 1'b0));
    send_sample(quat(32767, -32768, 32767, -32768, 1'b0));
    send_sample(quat(-32768, 0, 0, 0, 1'b0));
    send_sample(quat(0, 16384, 0, 0, 1'b0));
    send_sample(quat(0, 0, -32768, -32768, 1'b0));
    send_sample(quat(0, 0, 0, 16384, 1'b1));
    send_sample(quat(16384, 0, 0, 0, 1'b0));
    send_sample(quat(21845, -21846, 21845, -21846, 1'b0));
    send_sample(quat(-21846, 21845, -21846, 21845, 1'b0));
    send_sample(quat(32767, 32767, -32768, 0, 1'b1));
    send_sample(quat(0, -32768, 32767, 32767, 1'b0));
  endtask

  // a write after samples were summed must wait for the next restart
  task automatic test_write_during_calibration();
    wait_idle();
    write_calib_samples(8'd10);
    send_random_run(4);
    wait_idle();
    write_calib_samples(8'd3);
    for (int k = 0; k < 8; k++) send_sample(random_sample(1'b0));
    send_random_run(5);
  endtask

  task automatic test_calib_count_extremes();
    logic [7:0] counts[3];
    counts = '{8'd1, 8'd255, 8'd2};
    foreach (counts[k]) begin
      wait_idle();
      write_calib_samples(counts[k]);
      send_random_run(int'(counts[k]) + 16);
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    write_calib_samples(8'd4);
    @(posedge clk);
    out_hold_cycles = 300;
    send_random_run(30);
  endtask

  task automatic test_random_tracking();
    logic [7:0] calib_pick;
    while (samples_sent < ITEM_TARGET) begin
      wait_idle();
      calib_pick = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(41, 255)) :
                                                 8'($urandom_range(1, 40));
      if ($urandom_range(0, 15) == 0) calib_pick = 8'd0;
      write_calib_samples(calib_pick);
      idle_on = ($urandom_range(0, 3) != 0);
      send_random_run(int'(calib_target(calib_pick)) + $urandom_range(10, 80));
      idle_on = 1'b1;
    end
  endtask

  initial begin
    int          stall_left;
    yaw_result_t exp_r;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (yaw_expected.size() == 0) begin
          $error("unexpected result transaction: yaw_angle %0d raw_yaw %0d",
                 out_ch.yaw_angle, out_ch.raw_yaw);
          error_count++;
        end else begin
          exp_r = yaw_expected.pop_front();
          if (out_ch.yaw_angle !== exp_r.yaw_angle) begin
            $error("yaw_angle: expected %0d, got %0d", exp_r.yaw_angle, out_ch.yaw_angle);
            error_count++;
          end
          if (out_ch.yaw_centideg !== exp_r.yaw_centideg) begin
            $error("yaw_centideg: expected %0d, got %0d", exp_r.yaw_centideg,
                   out_ch.yaw_centideg);
            error_count++;
          end
          if (out_ch.raw_yaw !== exp_r.raw_yaw) begin
            $error("raw_yaw: expected %0d, got %0d", exp_r.raw_yaw, out_ch.raw_yaw);
            error_count++;
          end
          if (out_ch.calibrated !== exp_r.calibrated) begin
            $error("calibrated: expected %0d, got %0d", exp_r.calibrated, out_ch.calibrated);
            error_count++;
          end
        end
      end
      if (out_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        out_hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.quat_w <= '0;
    in_ch.quat_x <= '0;
    in_ch.quat_y <= '0;
    in_ch.quat_z <= '0;
    in_ch.restart_calibration <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_count_and_special_angles();
    test_write_during_calibration();
    test_calib_count_extremes();
    test_output_backpressure();
    test_random_tracking();
    wait_idle();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("** quaternion_yaw_tracker_unit: PASSED **");
    end else begin
      $display("** quaternion_yaw_tracker_unit: FAILED **");
    end
    $finish;
  end

endmodule
